FILE: rtl/core/acl_pkg.sv
// Shared types, op codes and ASCII constants for the register command link.
// Used by acl_front, acl_queue, acl_back, the top level and the checker.
package acl_pkg;

  // Input op codes
  localparam logic [2:0] OP_QUERY   = 3'd0;
  localparam logic [2:0] OP_COMMAND = 3'd1;
  localparam logic [2:0] OP_WRITE   = 3'd2;
  localparam logic [2:0] OP_RX_BYTE = 3'd3;
  localparam logic [2:0] OP_RX_END  = 3'd4;

  // ASCII characters
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_HEX_OFS = 8'h37;
  localparam logic [7:0] CH_QUERY   = 8'h3f;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_MINUS   = 8'h2d;

  // Decimal conversion of a 16-bit magnitude (up to 32768)
  localparam int BIN_W      = 16;
  localparam int BCD_DIGITS = 5;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int BCD_CNT_W  = $clog2(BIN_W + 1);

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    JOB_QUERY,
    JOB_COMMAND,
    JOB_WRITE,
    JOB_REPLY
  } job_kind_t;

  // One unit of work handed from the front to the back.
  // data is the write magnitude for writes and the reply value for replies.
  typedef struct packed {
    job_kind_t         kind;
    logic [11:0]       reg_addr;
    logic              has_bit;
    logic [3:0]        bit_nib;
    logic              neg;
    logic [BIN_W-1:0]  data;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    hex_char = (v > 4'd9) ? ({4'b0, v} + CH_HEX_OFS) : ({4'b0, v} + CH_ZERO);
  endfunction

endpackage

FILE: rtl/core/acl_front.sv
// Front end: accepts input items, keeps the reply parser state and queues jobs.
// Depends on acl_pkg.
module acl_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic [11:0]        reg_addr,
  input  logic [7:0]         bit_select,
  input  logic signed [15:0] write_value,
  input  logic [7:0]         rx_byte,
  input  logic               q_full,
  output logic               push,
  output acl_pkg::job_t      push_job
);

  logic [15:0] accumulator, accumulator_next;
  logic        minus_seen, minus_seen_next;
  logic        query_pending, query_pending_next;
  logic        accept;
  logic [15:0] wv_u;
  logic [15:0] mag;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign wv_u     = write_value;
  assign mag      = wv_u[15] ? (~wv_u + 16'd1) : wv_u;

  always_comb begin
    accumulator_next   = accumulator;
    minus_seen_next    = minus_seen;
    query_pending_next = query_pending;
    push               = 1'b0;
    push_job.kind      = acl_pkg::JOB_COMMAND;
    push_job.reg_addr  = reg_addr;
    push_job.has_bit   = (bit_select[7:4] == 4'd0);
    push_job.bit_nib   = bit_select[3:0];
    push_job.neg       = wv_u[15];
    push_job.data      = mag;
    if (accept) begin
      case (op)
        acl_pkg::OP_QUERY: begin
          push_job.kind      = acl_pkg::JOB_QUERY;
          push               = 1'b1;
          accumulator_next   = 16'd0;
          minus_seen_next    = 1'b0;
          query_pending_next = 1'b1;
        end
        acl_pkg::OP_COMMAND: begin
          push_job.kind      = acl_pkg::JOB_COMMAND;
          push               = 1'b1;
          accumulator_next   = 16'd0;
          minus_seen_next    = 1'b0;
          query_pending_next = 1'b0;
        end
        acl_pkg::OP_WRITE: begin
          push_job.kind      = acl_pkg::JOB_WRITE;
          push               = 1'b1;
          accumulator_next   = 16'd0;
          minus_seen_next    = 1'b0;
          query_pending_next = 1'b0;
        end
        acl_pkg::OP_RX_BYTE: begin
          if (query_pending) begin
            if (rx_byte >= acl_pkg::CH_ZERO && rx_byte <= acl_pkg::CH_NINE) begin
              // acc * 10 + digit, wrapping at 16 bits
              accumulator_next = (accumulator << 3) + (accumulator << 1)
                                 + {12'd0, rx_byte[3:0]};
            end else if (rx_byte == acl_pkg::CH_MINUS) begin
              minus_seen_next = 1'b1;
            end
          end
        end
        acl_pkg::OP_RX_END: begin
          if (query_pending) begin
            push_job.kind      = acl_pkg::JOB_REPLY;
            push_job.data      = minus_seen ? (~accumulator + 16'd1) : accumulator;
            push               = 1'b1;
            accumulator_next   = 16'd0;
            minus_seen_next    = 1'b0;
            query_pending_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= 16'd0;
      minus_seen    <= 1'b0;
      query_pending <= 1'b0;
    end else begin
      accumulator   <= accumulator_next;
      minus_seen    <= minus_seen_next;
      query_pending <= query_pending_next;
    end
  end

endmodule

FILE: rtl/core/acl_queue.sv
// Short job queue between the front and back ends (depth a power of two, >= 2).
// Depends on acl_pkg.
module acl_queue #(
  parameter int DEPTH = acl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  acl_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output acl_pkg::job_t pop_job,
  output logic          empty
);

  localparam int AW = $clog2(DEPTH);

  acl_pkg::job_t mem [DEPTH];
  logic [AW:0]   wptr, rptr;

  assign empty   = (wptr == rptr);
  assign full    = (wptr[AW] != rptr[AW]) && (wptr[AW-1:0] == rptr[AW-1:0]);
  assign pop_job = mem[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr[AW-1:0]] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/acl_back.sv
// Back end: serializes one job at a time into output beats, with a
// shift-and-add-3 decimal converter for write values. Depends on acl_pkg.
module acl_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  acl_pkg::job_t      q_job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         tx_byte,
  output logic               tx_valid,
  output logic               last,
  output logic signed [15:0] reply_value,
  output logic               reply_valid
);

  localparam int SH_W = acl_pkg::BCD_W + acl_pkg::BIN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CR1, S_LF1, S_H2, S_H1, S_H0, S_DOT, S_BITD,
    S_TERM, S_MINUS, S_LEAD, S_DIG, S_CR2, S_LF2, S_REPLY
  } state_t;

  state_t        state, adv_state;
  acl_pkg::job_t cur;
  logic [SH_W-1:0]               bcd;
  logic [acl_pkg::BCD_CNT_W-1:0] bcd_cnt;
  logic [2:0]    dig_idx, lead;
  logic [acl_pkg::BCD_W-1:0]     digits;
  logic [3:0]    digit;
  logic          emit, e_last, e_reply, load;
  logic [7:0]    e_byte;

  function automatic logic [SH_W-1:0] dabble(input logic [SH_W-1:0] s);
    logic [SH_W-1:0] t;
    t = s;
    for (int i = 0; i < acl_pkg::BCD_DIGITS; i++) begin
      if (t[acl_pkg::BIN_W + 4*i +: 4] >= 4'd5) begin
        t[acl_pkg::BIN_W + 4*i +: 4] = t[acl_pkg::BIN_W + 4*i +: 4] + 4'd3;
      end
    end
    dabble = t << 1;
  endfunction

  assign digits = bcd[SH_W-1:acl_pkg::BIN_W];
  assign digit  = digits[{dig_idx, 2'b00} +: 4];
  assign pop    = (state == S_IDLE) && !q_empty;
  assign load   = emit && (!out_valid || out_ready);

  // Highest nonzero digit, or the ones digit for zero
  always_comb begin
    lead = 3'd0;
    for (int i = 1; i < acl_pkg::BCD_DIGITS; i++) begin
      if (digits[4*i +: 4] != 4'd0) begin
        lead = 3'(i);
      end
    end
  end

  always_comb begin
    emit    = 1'b1;
    e_byte  = 8'h00;
    e_last  = 1'b0;
    e_reply = 1'b0;
    case (state)
      S_CR1, S_CR2: e_byte = acl_pkg::CH_CR;
      S_LF1:        e_byte = acl_pkg::CH_LF;
      S_LF2: begin
        e_byte = acl_pkg::CH_LF;
        e_last = 1'b1;
      end
      S_H2:    e_byte = acl_pkg::hex_char(cur.reg_addr[11:8]);
      S_H1:    e_byte = acl_pkg::hex_char(cur.reg_addr[7:4]);
      S_H0:    e_byte = acl_pkg::hex_char(cur.reg_addr[3:0]);
      S_DOT:   e_byte = acl_pkg::CH_DOT;
      S_BITD:  e_byte = acl_pkg::hex_char(cur.bit_nib);
      S_TERM: begin
        case (cur.kind)
          acl_pkg::JOB_QUERY: e_byte = acl_pkg::CH_QUERY;
          acl_pkg::JOB_WRITE: e_byte = acl_pkg::CH_EQUAL;
          default:            e_byte = acl_pkg::CH_BANG;
        endcase
      end
      S_MINUS: e_byte = acl_pkg::CH_MINUS;
      S_DIG:   e_byte = acl_pkg::CH_ZERO + {4'd0, digit};
      S_REPLY: begin
        e_reply = 1'b1;
        e_last  = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    case (state)
      S_CR1:   adv_state = S_LF1;
      S_LF1:   adv_state = S_H2;
      S_H2:    adv_state = S_H1;
      S_H1:    adv_state = S_H0;
      S_H0:    adv_state = (cur.kind != acl_pkg::JOB_COMMAND && cur.has_bit) ? S_DOT
                                                                              : S_TERM;
      S_DOT:   adv_state = S_BITD;
      S_BITD:  adv_state = S_TERM;
      S_TERM: begin
        if (cur.kind == acl_pkg::JOB_WRITE) begin
          adv_state = cur.neg ? S_MINUS : S_LEAD;
        end else begin
          adv_state = S_CR2;
        end
      end
      S_MINUS: adv_state = S_LEAD;
      S_DIG:   adv_state = (dig_idx == 3'd0) ? S_CR2 : S_DIG;
      S_CR2:   adv_state = S_LF2;
      default: adv_state = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      bcd_cnt   <= '0;
    end else begin
      // load a new job's value, else advance the decimal conversion beside the header beats
      if (pop) begin
        bcd     <= {{acl_pkg::BCD_W{1'b0}}, q_job.data};
        bcd_cnt <= acl_pkg::BCD_CNT_W'(acl_pkg::BIN_W);
      end else if (bcd_cnt != '0) begin
        bcd     <= dabble(bcd);
        bcd_cnt <= bcd_cnt - 1'b1;
      end
      if (load) begin
        out_valid   <= 1'b1;
        tx_byte     <= e_byte;
        tx_valid    <= !e_reply;
        last        <= e_last;
        reply_valid <= e_reply;
        reply_value <= e_reply ? cur.data : 16'd0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            cur   <= q_job;
            state <= (q_job.kind == acl_pkg::JOB_REPLY) ? S_REPLY : S_CR1;
          end
        end
        S_LEAD: begin
          if (bcd_cnt == '0) begin
            dig_idx <= lead;
            state   <= S_DIG;
          end
        end
        default: begin
          if (load) begin
            state <= adv_state;
            if (state == S_DIG && dig_idx != 3'd0) begin
              dig_idx <= dig_idx - 3'd1;
            end
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/ascii_register_command_link_unit.sv
// Path: an accepted request is written into the queue, popped into the back end's job register
// when that is idle, and its beats leave through the registered output beat. Output runs one
// beat per cycle while out_ready holds, apart from the idle state between jobs; a write holds
// before its digits until the decimal converter is done, since the back end runs one job.
// Reset (rst, synchronous): clears the reply parser, empties the queue, drops any beat.
// Depends on acl_pkg, acl_front, acl_queue, acl_back.
module ascii_register_command_link_unit #(
  parameter int QUEUE_DEPTH = acl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // request / reply-character channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic [11:0]        reg_addr,
  input  logic [7:0]         bit_select,
  input  logic signed [15:0] write_value,
  input  logic [7:0]         rx_byte,
  // result beat channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         tx_byte,
  output logic               tx_valid,
  output logic               last,
  output logic signed [15:0] reply_value,
  output logic               reply_valid
);

  // Front classifies each item and updates the reply parser at once; only
  // items that produce beats become jobs in the queue.
  logic          push, pop, q_full, q_empty;
  acl_pkg::job_t push_job, pop_job;

  acl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .reg_addr    (reg_addr),
    .bit_select  (bit_select),
    .write_value (write_value),
    .rx_byte     (rx_byte),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  // Queue decouples the two ends: hold new requests while beats drain.
  acl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // Back end walks each job's byte sequence into a registered output beat.
  acl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_job       (pop_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tx_byte     (tx_byte),
    .tx_valid    (tx_valid),
    .last        (last),
    .reply_value (reply_value),
    .reply_valid (reply_valid)
  );

endmodule

FILE: rtl/core/acl_checker.sv
// Port-level checker for the register command link, bound to the top level.
// Depends on acl_pkg and ascii_register_command_link_unit.
module acl_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         tx_byte,
  input logic               tx_valid,
  input logic               last,
  input logic signed [15:0] reply_value,
  input logic               reply_valid
);

  // A stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(last)
      && $stable(reply_value))
    else $error("stalled beat changed");

  // Every beat is either a transmit byte or a reply, never both
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tx_valid ^ reply_valid))
    else $error("beat kind invalid");

  // A reply is a single-beat result
  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_valid |-> last && tx_byte == acl_pkg::CH_ZERO - acl_pkg::CH_ZERO)
    else $error("reply beat not last");

  // Every request ends on a line feed
  a_lf_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_valid && last |-> tx_byte == acl_pkg::CH_LF)
    else $error("request did not end on LF");

  // Reset drops any pending beat
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("beat visible after reset");

endmodule

bind ascii_register_command_link_unit acl_checker u_acl_checker (.*);
